FILE: design/skvt_pkg.sv
// Shared types and constants for the sorted key/value table lookup block.
`default_nettype none
package skvt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int ENTRY_W = KEY_W + VAL_W;

  // request kind codes (in_tuser)
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PROBE,
    S_COMPARE,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch the accepted request
    logic append;       // store pair if room, build append result
    logic search_init;  // left = 0, bound = count
    logic probe;        // read entry at midpoint
    logic narrow;       // move a bound after a mismatch
    logic hit;          // build found result from read entry
    logic miss;         // build empty result
    logic load_out;     // move result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_lookup;
    logic span_empty;
    logic key_eq;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/skvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module skvt_ram #(
  parameter int WIDTH = skvt_pkg::ENTRY_W,
  parameter int DEPTH = skvt_pkg::TABLE_DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: design/skvt_ctrl.sv
// Sequencer for append and binary-search lookup requests.
`default_nettype none
module skvt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire skvt_pkg::sts_t sts,
  output skvt_pkg::cmd_t     cmd
);

  skvt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skvt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      skvt_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = skvt_pkg::S_CHECK;
        end
      end
      skvt_pkg::S_CHECK: begin
        if (sts.is_lookup) begin
          cmd.search_init = 1'b1;
          state_nxt       = skvt_pkg::S_PROBE;
        end else begin
          cmd.append = 1'b1;
          state_nxt  = skvt_pkg::S_DONE;
        end
      end
      skvt_pkg::S_PROBE: begin
        if (sts.span_empty) begin
          cmd.miss  = 1'b1;
          state_nxt = skvt_pkg::S_DONE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = skvt_pkg::S_COMPARE;
        end
      end
      skvt_pkg::S_COMPARE: begin
        if (sts.key_eq) begin
          cmd.hit   = 1'b1;
          state_nxt = skvt_pkg::S_DONE;
        end else begin
          cmd.narrow = 1'b1;
          state_nxt  = skvt_pkg::S_PROBE;
        end
      end
      skvt_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = skvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = skvt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over an unread result");

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == skvt_pkg::S_CHECK))
    else $error("accepted request not dispatched");

  a_compare_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skvt_pkg::S_COMPARE) |-> $past(cmd.probe))
    else $error("compare without a memory read");
`endif

endmodule
`default_nettype wire

FILE: design/skvt_dp.sv
// Datapath: table memory, fill count, search bounds and result registers.
`default_nettype none
module skvt_dp #(
  parameter int TABLE_DEPTH = skvt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire skvt_pkg::cmd_t                cmd,
  output skvt_pkg::sts_t                     sts,
  input  wire logic [skvt_pkg::ENTRY_W-1:0]  in_tdata,
  input  wire logic                          in_tuser,
  output logic      [skvt_pkg::ENTRY_W-1:0]  out_tdata,
  output logic      [1:0]                    out_tuser
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = skvt_pkg::KEY_W;
  localparam int VW = skvt_pkg::VAL_W;

  logic          kind_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] value_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] left_r, bound_r;   // search span is [left, bound)
  logic [AW-1:0] mid_r;

  logic          res_found_r, res_err_r;
  logic [KW-1:0] res_key_r;
  logic [VW-1:0] res_val_r;
  logic [skvt_pkg::ENTRY_W-1:0] out_data_r;
  logic [1:0]                   out_user_r;

  logic                         table_full;
  logic [CW-1:0]                span_m1, mid_full;
  logic [AW-1:0]                mid_c;
  logic [skvt_pkg::ENTRY_W-1:0] rdata;
  logic [KW-1:0]                rd_key;
  logic [VW-1:0]                rd_val;
  logic                         key_lt;

  assign table_full = (count_r == CW'(TABLE_DEPTH));

  // mid = left + floor((right - left) / 2), right = bound - 1
  assign span_m1  = bound_r - left_r - CW'(1);
  assign mid_full = left_r + (span_m1 >> 1);
  assign mid_c    = mid_full[AW-1:0];

  skvt_ram #(
    .WIDTH (skvt_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.append && !table_full),
    .waddr (count_r[AW-1:0]),
    .wdata ({value_r, key_r}),
    .re    (cmd.probe),
    .raddr (mid_c),
    .rdata (rdata)
  );

  assign rd_key = rdata[KW-1:0];
  assign rd_val = rdata[skvt_pkg::ENTRY_W-1:KW];
  assign key_lt = $signed(key_r) < $signed(rd_key);

  assign sts.is_lookup  = (kind_r == skvt_pkg::KIND_LOOKUP);
  assign sts.span_empty = (left_r >= bound_r);
  assign sts.key_eq     = (rd_key == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.append && !table_full) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_tuser;
      key_r   <= in_tdata[KW-1:0];
      value_r <= in_tdata[skvt_pkg::ENTRY_W-1:KW];
    end
    if (cmd.search_init) begin
      left_r  <= '0;
      bound_r <= count_r;
    end
    if (cmd.probe) begin
      mid_r <= mid_c;
    end
    if (cmd.narrow) begin
      if (key_lt) begin
        bound_r <= CW'(mid_r);
      end else begin
        left_r <= CW'(mid_r) + CW'(1);
      end
    end
    if (cmd.append) begin
      res_found_r <= 1'b0;
      res_err_r   <= table_full;
      res_key_r   <= '0;
      res_val_r   <= '0;
    end
    if (cmd.miss) begin
      res_found_r <= 1'b0;
      res_err_r   <= 1'b0;
      res_key_r   <= '0;
      res_val_r   <= '0;
    end
    if (cmd.hit) begin
      res_found_r <= 1'b1;
      res_err_r   <= 1'b0;
      res_key_r   <= rd_key;
      res_val_r   <= rd_val;
    end
    if (cmd.load_out) begin
      out_data_r <= {res_val_r, res_key_r};
      out_user_r <= {res_err_r, res_found_r};
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("fill count past table depth");

  a_probe_filled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> (CW'(mid_c) < count_r))
    else $error("probe outside filled entries");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.append && !table_full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("append did not advance fill count");

  a_narrow_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.narrow && key_lt) |=> (bound_r == CW'($past(mid_r))))
    else $error("upper bound not moved to probe point");
`endif

endmodule
`default_nettype wire

FILE: design/sorted_key_value_table_lookup_core.sv
// Top level: sorted key/value table with binary-search lookup.
//
// Input channel (in_*): one request per handshake. in_tuser is the kind
// (append or lookup); in_tdata carries key in [31:0] and value in [63:32].
// Output channel (out_*): exactly one result per request, in request order.
// out_tuser[0] = found, out_tuser[1] = full_error; out_tdata holds
// match_key in [31:0] and match_value in [63:32], zero unless found.
// Append: a full table drops the pair and flags full_error.
// Lookup: at most log2(TABLE_DEPTH) + 1 probes (nine for 256 entries).
//   Each probe is one registered read of the table RAM and a signed compare.
// One request is in work at a time; in_tready is high only while the
// sequencer is idle, from the cycle after a result is loaded.
// The output register lets the next request be taken while a result waits;
// a stalled receiver holds the finished next result in the datapath until
// the output register frees up.
// Reset (rst_n low, synchronous) empties the table (fill count to zero) and
// drops any result waiting on the output; table contents need no clearing.
`default_nettype none
module sorted_key_value_table_lookup_core #(
  parameter int TABLE_DEPTH = skvt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [skvt_pkg::ENTRY_W-1:0]  in_tdata,   // key, value
  input  wire logic                          in_tuser,   // kind
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [skvt_pkg::ENTRY_W-1:0]  out_tdata,  // match_key, match_value
  output logic      [1:0]                    out_tuser   // found, full_error
);

  skvt_pkg::cmd_t cmd;
  skvt_pkg::sts_t sts;

  // sequencer: one request at a time, probe/compare loop for lookups
  skvt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // table RAM, fill count, search span and result/output registers
  skvt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire
